[rtl/bgd_pkg.sv]
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared types, state and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned STAMP_WIDTH_DEF = 32;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST  = 16'd400;
  localparam logic [CFG_W-1:0] RELEASE_GUARD_RST = 16'd100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GUARD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_LONG     = 3'd3,
    ST_GUARD    = 3'd4,
    ST_DWAIT    = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef struct packed {
    logic        button_level;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0] gesture_event;
    logic [2:0] fsm_state_out;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
    logic [CFG_W-1:0] release_guard_ms;
  } cfg_t;

endpackage

[rtl/button_gesture_detector.sv]
// ----------------------------------------------------------------------------
// Button gesture detector
// Turns button poll samples into single click, double click and long press.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle while the consumer does not stall;
// the single-pass step logic sits between the input register and the result
// register, which hold an accepted sample and then its result word.
// Reset: asynchronous, active low; the machine returns to idle with cleared
// stamps, tally and flags, and the thresholds take 50, 1000, 400 and 100 ms.
module button_gesture_detector #(
  parameter int unsigned STAMP_WIDTH = bgd_pkg::STAMP_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bgd_pkg::in_word_t             in_word_i,
  // Result output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bgd_pkg::out_word_t            out_word_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import bgd_pkg::*;

  // Input register: one sample word waiting for the step logic.
  logic      in_valid_q, in_valid_d;
  in_word_t  in_word_q;

  // Result register: one finished word waiting for the consumer.
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  cfg_t      cfg;
  out_word_t step_result;
  logic      advance;
  logic      in_accept;

  // The held sample is processed when the result register is free or is
  // being emptied in this same cycle, so words stream at full rate.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= step_result;
    end
  end

  bgd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The gesture state moves forward exactly once per processed sample.
  bgd_fsm #(
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (in_word_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/bgd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Button gesture detector configuration registers
// Holds the four timing thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module bgd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_wdata_i,
  output bgd_pkg::cfg_t                cfg_o
);
  import bgd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:      cfg_d.debounce_ms      = cfg_wdata_i;
        REG_LONG_PRESS:    cfg_d.long_press_ms    = cfg_wdata_i;
        REG_DOUBLE_CLICK:  cfg_d.double_click_ms  = cfg_wdata_i;
        REG_RELEASE_GUARD: cfg_d.release_guard_ms = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DEBOUNCE_RST;
      cfg_q.long_press_ms    <= LONG_PRESS_RST;
      cfg_q.double_click_ms  <= DOUBLE_CLICK_RST;
      cfg_q.release_guard_ms <= RELEASE_GUARD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/bgd_fsm.sv]
// ----------------------------------------------------------------------------
// Button gesture detector state machine
// Holds the gesture state and computes one step and its event per sample.
// ----------------------------------------------------------------------------
module bgd_fsm #(
  parameter int unsigned STAMP_WIDTH = bgd_pkg::STAMP_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  bgd_pkg::in_word_t    word_i,
  input  bgd_pkg::cfg_t        cfg_i,
  output bgd_pkg::out_word_t   result_o
);
  import bgd_pkg::*;

  state_e                 state_q, state_d;
  logic [STAMP_WIDTH-1:0] press_q, press_d;
  logic [STAMP_WIDTH-1:0] rel_q, rel_d;
  logic [1:0]             tally_q, tally_d;
  logic                   long_q, long_d;
  logic                   dbl_q, dbl_d;

  logic [STAMP_WIDTH-1:0] now_stamp;
  logic [STAMP_WIDTH-1:0] el_press;
  logic [STAMP_WIDTH-1:0] el_rel;
  logic [1:0]             tally_inc;
  logic                   pressed;
  event_e                 ev;

  assign pressed   = word_i.button_level;
  assign now_stamp = STAMP_WIDTH'(word_i.now_ms);
  assign el_press  = now_stamp - press_q;
  assign el_rel    = now_stamp - rel_q;
  assign tally_inc = tally_q + 2'd1;

  // Next state and bookkeeping for one sample.
  always_comb begin
    state_d = state_q;
    press_d = press_q;
    rel_d   = rel_q;
    tally_d = tally_q;
    long_d  = long_q;
    dbl_d   = dbl_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pressed) begin
          state_d = ST_DEBOUNCE;
          press_d = now_stamp;
          long_d  = 1'b0;
          dbl_d   = 1'b0;
        end
      end
      ST_DEBOUNCE: begin
        if (!pressed) begin
          state_d = ST_IDLE;
        end else if (el_press >= STAMP_WIDTH'(cfg_i.debounce_ms)) begin
          state_d = ST_PRESSED;
          press_d = now_stamp;
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          state_d = ST_GUARD;
          rel_d   = now_stamp;
          if (el_press < STAMP_WIDTH'(cfg_i.long_press_ms)) begin
            tally_d = tally_inc;
            if (tally_inc == 2'd1) begin
              state_d = ST_DWAIT;
            end else if (tally_inc == 2'd2) begin
              dbl_d   = 1'b1;
              tally_d = 2'd0;
            end
          end
        end else if (el_press >= STAMP_WIDTH'(cfg_i.long_press_ms)) begin
          state_d = ST_LONG;
          long_d  = 1'b1;
          tally_d = 2'd0;
        end
      end
      ST_LONG: begin
        if (!pressed) begin
          state_d = ST_GUARD;
          rel_d   = now_stamp;
        end
      end
      ST_GUARD: begin
        if (el_rel >= STAMP_WIDTH'(cfg_i.release_guard_ms)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DWAIT: begin
        if (pressed) begin
          tally_d = tally_inc;
          if (tally_inc == 2'd2) begin
            dbl_d   = 1'b1;
            tally_d = 2'd0;
          end
          state_d = ST_DEBOUNCE;
          press_d = now_stamp;
        end else if (el_rel >= STAMP_WIDTH'(cfg_i.double_click_ms)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Report one event by priority and clear what was reported.
    ev = EV_NONE;
    if (long_d) begin
      long_d = 1'b0;
      ev     = EV_LONG;
    end else if (dbl_d) begin
      dbl_d = 1'b0;
      ev    = EV_DOUBLE;
    end else if (tally_d == 2'd1 && state_d == ST_IDLE) begin
      tally_d = 2'd0;
      ev      = EV_SINGLE;
    end
  end

  always_comb begin
    result_o.gesture_event = ev;
    result_o.fsm_state_out = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      press_q <= '0;
      rel_q   <= '0;
      tally_q <= 2'd0;
      long_q  <= 1'b0;
      dbl_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      press_q <= press_d;
      rel_q   <= rel_d;
      tally_q <= tally_d;
      long_q  <= long_d;
      dbl_q   <= dbl_d;
    end
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Button gesture detector testbench
// Feeds poll sample words (level and millisecond stamp) through the valid and
// stall handshake, predicts each result word in the bench itself or takes it
// from the directed table, and checks each one field by field against the oldest still waiting.
// ----------------------------------------------------------------------------
module tb_top;
  import bgd_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RST_CYCLES      = 9;
  // Result words pass the input and result registers after their sample, so
  // these spare cycles are enough to know the pipeline is empty.
  localparam int SETTLE_CYCLES   = 6;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 116;
  localparam int DIR_ROWS        = 25;

  // One row of the directed table. When check_typed is set, the result word is
  // taken from the row itself; otherwise the gesture predictor supplies it.
  typedef struct packed {
    logic        level;
    logic [31:0] stamp;
    logic        check_typed;
    event_e      ev;
    state_e      st;
  } sample_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // Mirror of the block's thresholds and gesture state, kept by the predictor.
  cfg_t        thr = '{DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST, RELEASE_GUARD_RST};
  state_e      g_state    = ST_IDLE;
  logic [31:0] g_press_t  = '0;
  logic [31:0] g_rel_t    = '0;
  logic [1:0]  g_tally    = '0;
  logic        g_long     = 1'b0;
  logic        g_double   = 1'b0;

  out_word_t   gesture_q[$];   // result words still owed by the block
  int unsigned fails      = 0;
  int unsigned cycles     = 0;
  bit          idle_on    = 1'b1;
  int unsigned stall_run  = 0;

  // Random sample stream: the level alternates in runs of a few samples so
  // that presses, holds and releases form real gestures; runs of one sample
  // act as contact bounce. The stamp advances by steps scaled to the
  // thresholds, and now and then jumps anywhere, which also wraps the clock.
  logic        rnd_level  = 1'b0;
  int unsigned rnd_run    = 0;
  logic [31:0] rnd_now    = '0;
  int unsigned step_span  = 400;

  sample_row_t sample_tab [0:DIR_ROWS-1] = '{
    // Quiet line right after reset, stamp at its minimum.
    '{1'b0, 32'd0,          1'b1, EV_NONE,   ST_IDLE},
    // A bounce: pressed for one sample, then released before debounce ends.
    '{1'b1, 32'd10,         1'b1, EV_NONE,   ST_DEBOUNCE},
    '{1'b0, 32'd20,         1'b1, EV_NONE,   ST_IDLE},
    // Single click: the double-click window runs out exactly on its limit.
    '{1'b1, 32'd100,        1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'd150,        1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd300,        1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd700,        1'b1, EV_SINGLE, ST_IDLE},
    // Double click: the second press lands inside the window.
    '{1'b1, 32'd1000,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'd1060,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd1100,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'd1200,       1'b1, EV_DOUBLE, ST_DEBOUNCE},
    // The press after a double click starts a fresh count.
    '{1'b1, 32'd1250,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd1300,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd1700,       1'b1, EV_SINGLE, ST_IDLE},
    // Long press declared exactly at the threshold, then released through
    // the guard, which ends exactly on its limit.
    '{1'b1, 32'd2000,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'd2050,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'd3050,       1'b1, EV_LONG,   ST_LONG},
    '{1'b1, 32'd5000,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd5001,       1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'd5101,       1'b0, EV_NONE,   ST_IDLE},
    // A click across the stamp wrap, ending at the largest stamp.
    '{1'b1, 32'hFFFF_FFF0,  1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'h0000_0020,  1'b0, EV_NONE,   ST_IDLE},
    '{1'b1, 32'h0000_0022,  1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'h0000_0030,  1'b0, EV_NONE,   ST_IDLE},
    '{1'b0, 32'hFFFF_FFFF,  1'b1, EV_SINGLE, ST_IDLE}
  };

  button_gesture_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Advances the gesture state by one sample and returns the word the block
  // owes for it. Elapsed times are plain 32-bit differences, so they wrap.
  function automatic out_word_t predict_gesture(input in_word_t w);
    out_word_t   r;
    event_e      ev;
    logic [31:0] held;
    logic [31:0] since_rel;
    ev        = EV_NONE;
    held      = w.now_ms - g_press_t;
    since_rel = w.now_ms - g_rel_t;
    case (g_state)
      ST_IDLE: begin
        if (w.button_level) begin
          g_state   = ST_DEBOUNCE;
          g_press_t = w.now_ms;
          g_long    = 1'b0;
          g_double  = 1'b0;
        end
      end
      ST_DEBOUNCE: begin
        if (!w.button_level) begin
          g_state = ST_IDLE;
        end else if (held >= 32'(thr.debounce_ms)) begin
          g_state   = ST_PRESSED;
          g_press_t = w.now_ms;
        end
      end
      ST_PRESSED: begin
        if (!w.button_level) begin
          g_state = ST_GUARD;
          g_rel_t = w.now_ms;
          // Only a short hold counts as a click.
          if (held < 32'(thr.long_press_ms)) begin
            g_tally = g_tally + 2'd1;
            if (g_tally == 2'd1) begin
              g_state = ST_DWAIT;
            end else if (g_tally == 2'd2) begin
              g_double = 1'b1;
              g_tally  = 2'd0;
            end
          end
        end else if (held >= 32'(thr.long_press_ms)) begin
          g_state = ST_LONG;
          g_long  = 1'b1;
          g_tally = 2'd0;
        end
      end
      ST_LONG: begin
        if (!w.button_level) begin
          g_state = ST_GUARD;
          g_rel_t = w.now_ms;
        end
      end
      ST_GUARD: begin
        if (since_rel >= 32'(thr.release_guard_ms)) g_state = ST_IDLE;
      end
      ST_DWAIT: begin
        if (w.button_level) begin
          g_tally = g_tally + 2'd1;
          if (g_tally == 2'd2) begin
            g_double = 1'b1;
            g_tally  = 2'd0;
          end
          g_state   = ST_DEBOUNCE;
          g_press_t = w.now_ms;
        end else if (since_rel >= 32'(thr.double_click_ms)) begin
          g_state = ST_IDLE;
        end
      end
      default: g_state = ST_IDLE;
    endcase
    // At most one event per sample, long before double before single.
    if (g_long) begin
      g_long = 1'b0;
      ev     = EV_LONG;
    end else if (g_double) begin
      g_double = 1'b0;
      ev       = EV_DOUBLE;
    end else if (g_tally == 2'd1 && g_state == ST_IDLE) begin
      g_tally = 2'd0;
      ev      = EV_SINGLE;
    end
    r.gesture_event = ev;
    r.fsm_state_out = g_state;
    return r;
  endfunction

  // Offers one sample word, optionally after a burst of idle cycles, and
  // records what the block must answer once the word is taken.
  task automatic send_sample(input in_word_t w, input logic use_typed, input out_word_t typed);
    out_word_t guess;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    guess = predict_gesture(w);
    gesture_q.push_back(use_typed ? typed : guess);
  endtask

  // Holds the input back until every owed word has come out, then lets the
  // pipeline settle so that the block is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four thresholds one after another; the block must be idle.
  task automatic program_thresholds(input cfg_t c);
    logic [CFG_W-1:0] vals [4];
    vals[0] = c.debounce_ms;
    vals[1] = c.long_press_ms;
    vals[2] = c.double_click_ms;
    vals[3] = c.release_guard_ms;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    thr = c;
  endtask

  task automatic next_random_sample(output in_word_t w);
    if (rnd_run == 0) begin
      rnd_level = ~rnd_level;
      rnd_run   = $urandom_range(1, 6);
    end
    rnd_run = rnd_run - 1;
    if ($urandom_range(0, 23) == 0) rnd_now = $urandom;
    else rnd_now = rnd_now + $urandom_range(0, step_span);
    w.button_level = rnd_level;
    w.now_ms       = rnd_now;
  endtask

  // Sender: reset, the directed table, then random phases under several
  // threshold settings, extremes included.
  initial begin
    in_word_t    w;
    out_word_t   typed;
    cfg_t        c;
    int unsigned biggest;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      w.button_level      = sample_tab[i].level;
      w.now_ms            = sample_tab[i].stamp;
      typed.gesture_event = sample_tab[i].ev;
      typed.fsm_state_out = sample_tab[i].st;
      send_sample(w, sample_tab[i].check_typed, typed);
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: c = thr;
        1: c = '0;
        2: c = '1;
        3: begin
          c.debounce_ms      = CFG_W'($urandom_range(0, 300));
          c.long_press_ms    = CFG_W'($urandom_range(0, 300));
          c.double_click_ms  = CFG_W'($urandom_range(0, 300));
          c.release_guard_ms = CFG_W'($urandom_range(0, 300));
        end
        4: begin
          c.debounce_ms      = CFG_W'($urandom_range(0, 65535));
          c.long_press_ms    = CFG_W'($urandom_range(0, 65535));
          c.double_click_ms  = CFG_W'($urandom_range(0, 65535));
          c.release_guard_ms = CFG_W'($urandom_range(0, 65535));
        end
        default: c = '{DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_CLICK_RST, RELEASE_GUARD_RST};
      endcase
      if (p != 0) program_thresholds(c);
      // The last phase runs flat out on both sides.
      if (p == PHASES - 1) idle_on = 1'b0;

      biggest = 32'(c.debounce_ms);
      if (32'(c.long_press_ms) > biggest) biggest = 32'(c.long_press_ms);
      if (32'(c.double_click_ms) > biggest) biggest = 32'(c.double_click_ms);
      if (32'(c.release_guard_ms) > biggest) biggest = 32'(c.release_guard_ms);
      step_span = biggest / 3 + 2;

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // Halfway through one phase the sender waits for the block to catch up.
        if (p == 3 && k == WORDS_PER_PHASE / 2) drain_results();
        next_random_sample(w);
        send_sample(w, 1'b0, typed);
      end
      drain_results();
    end

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: stalls come in bursts, split by stretches without any stall.
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
      stall_run   <= $urandom_range(0, 20);
    end
  end

  // Every accepted result word is matched against the oldest owed word.
  always @(posedge clk_i) begin : check_results
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gesture_q.size() == 0) begin
        $error("unexpected word: gesture_event %0d fsm_state_out %0d",
               out_word_o.gesture_event, out_word_o.fsm_state_out);
        fails++;
      end else begin
        want = gesture_q.pop_front();
        if (out_word_o.gesture_event !== want.gesture_event) begin
          $error("gesture_event: expected %0d, got %0d",
                 want.gesture_event, out_word_o.gesture_event);
          fails++;
        end
        if (out_word_o.fsm_state_out !== want.fsm_state_out) begin
          $error("fsm_state_out: expected %0d, got %0d",
                 want.fsm_state_out, out_word_o.fsm_state_out);
          fails++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a word that never arrives ends the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
